[rtl/ioli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioli_pkg
// Shared types and constants of the indexed ordered list unit.
// ----------------------------------------------------------------------------
package ioli_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 5;
  localparam int STAT_W       = 2;
  localparam int FIDX_W       = 4;
  localparam int CNT_W        = 5;
  localparam int DEF_CAPACITY = 16;
  localparam int SCAN_LANES   = 8;
  localparam int LANE_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT   = 3'd0,
    OP_APPEND      = 3'd1,
    OP_REMOVE_AT   = 3'd2,
    OP_REMOVE_LAST = 3'd3,
    OP_SEARCH      = 3'd4,
    OP_READ_AT     = 3'd5
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_NOP  = 3'd0,
    CMD_INS  = 3'd1,
    CMD_REM  = 3'd2,
    CMD_MEQ  = 3'd3,
    CMD_MPOS = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_SCAN = 2'b10
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] key;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic last;
  } scan_st_t;

endpackage

[rtl/ioli_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioli_cell
// One list slot: shifts with its neighbors on insert/remove, marks a flag
// for key match or position select.
// ----------------------------------------------------------------------------
module ioli_cell #(
  parameter int CW = 5
) (
  input  logic                          clk_i,
  input  ioli_pkg::ctrl_t               ctrl_i,
  input  logic [CW-1:0]                 at_i,
  input  logic [CW-1:0]                 idx_i,
  input  logic [ioli_pkg::DATA_W-1:0]   left_i,
  input  logic [ioli_pkg::DATA_W-1:0]   right_i,
  output logic [ioli_pkg::DATA_W-1:0]   value_o,
  output logic                          flag_o
);

  logic [ioli_pkg::DATA_W-1:0] value_q, value_d;
  logic                        flag_q, flag_d;

  always_comb begin
    value_d = value_q;
    flag_d  = flag_q;
    case (ctrl_i.cmd)
      ioli_pkg::CMD_INS: begin
        if (idx_i > at_i) begin
          value_d = left_i;
        end else if (idx_i == at_i) begin
          value_d = ctrl_i.key;
        end
      end
      ioli_pkg::CMD_REM: begin
        if (idx_i >= at_i) begin
          value_d = right_i;
        end
      end
      ioli_pkg::CMD_MEQ: begin
        flag_d = (idx_i < at_i) && (value_q == ctrl_i.key);
      end
      ioli_pkg::CMD_MPOS: begin
        flag_d = (idx_i == at_i);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    flag_q  <= flag_d;
  end

  assign value_o = value_q;
  assign flag_o  = flag_q;

endmodule

[rtl/ioli_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioli_scan
// Walks the cell flags eight cells per cycle and returns the first flagged
// cell's index and value.
// ----------------------------------------------------------------------------
module ioli_scan #(
  parameter int NCH = 2
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic                                      step_i,
  input  logic [NCH*ioli_pkg::SCAN_LANES-1:0]       flags_i,
  input  logic [ioli_pkg::DATA_W-1:0]               values_i [NCH*ioli_pkg::SCAN_LANES],
  output ioli_pkg::scan_st_t                        st_o,
  output logic [$clog2(NCH)+ioli_pkg::LANE_W-1:0]   idx_o,
  output logic [ioli_pkg::DATA_W-1:0]               value_o
);

  localparam int CHW = $clog2(NCH);

  logic [CHW-1:0]                    ch_q;
  logic [ioli_pkg::SCAN_LANES-1:0]   lane_flags;
  logic [ioli_pkg::LANE_W-1:0]       sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (start_i) begin
      ch_q <= '0;
    end else if (step_i) begin
      ch_q <= ch_q + CHW'(1);
    end
  end

  assign lane_flags = flags_i[{ch_q, ioli_pkg::LANE_W'(0)} +: ioli_pkg::SCAN_LANES];

  always_comb begin
    sel = '0;
    for (int j = ioli_pkg::SCAN_LANES - 1; j >= 0; j--) begin
      if (lane_flags[j]) begin
        sel = ioli_pkg::LANE_W'(j);
      end
    end
  end

  assign idx_o      = {ch_q, sel};
  assign value_o    = values_i[{ch_q, sel}];
  assign st_o.hit   = |lane_flags;
  assign st_o.last  = (ch_q == CHW'(NCH - 1));

endmodule

[rtl/indexed_ordered_list_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_unit
// Bounded ordered list of signed 32-bit values held in a row of cells.
//
// Input channel (in_valid_i / in_stall_o) carries opcode, value, position;
// output channel (out_valid_o / out_stall_i) carries status, read value,
// found index and entry count. A transfer happens when valid is high and
// stall is low. Each request gives exactly one result.
// Insert, append, remove, remove-last, undefined opcodes and out-of-range
// requests: result is registered at the input transfer and valid in the next
// cycle, one request per cycle while the receiver does not stall. Search and
// read_at: the cells mark their flags in the transfer cycle, then a scanner
// walks them eight cells per cycle until it finds a flagged cell or reaches
// the last group; the input is stalled until the result is loaded.
// Reset empties the list; entry contents stay unknown until written.
// When the receiver stalls, the result register holds and the input is
// stalled until the result can be replaced.
// ----------------------------------------------------------------------------
module indexed_ordered_list_unit #(
  parameter int CAPACITY = ioli_pkg::DEF_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ioli_pkg::OP_W-1:0]       opcode_i,
  input  logic signed [ioli_pkg::DATA_W-1:0] value_i,
  input  logic [ioli_pkg::POS_W-1:0]      position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ioli_pkg::STAT_W-1:0]     status_o,
  output logic signed [ioli_pkg::DATA_W-1:0] read_value_o,
  output logic [ioli_pkg::FIDX_W-1:0]     found_index_o,
  output logic [ioli_pkg::CNT_W-1:0]      entry_count_o
);

  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int XW      = (CW > ioli_pkg::POS_W) ? CW : ioli_pkg::POS_W;
  localparam int NCH_RAW = (CAPACITY + ioli_pkg::SCAN_LANES - 1) / ioli_pkg::SCAN_LANES;
  localparam int NCH     = (NCH_RAW < 2) ? 2 : NCH_RAW;
  localparam int SW      = $clog2(NCH) + ioli_pkg::LANE_W;
  localparam int NS      = NCH * ioli_pkg::SCAN_LANES;

  ioli_pkg::state_e            state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  logic                        search_q;
  logic [ioli_pkg::STAT_W-1:0] status_q;
  logic [ioli_pkg::DATA_W-1:0] rd_q;
  logic [ioli_pkg::FIDX_W-1:0] fidx_q;
  logic [ioli_pkg::CNT_W-1:0]  ent_q;

  logic                        in_acc, out_free, load_now, load_scan, go_scan;
  logic [XW-1:0]               cnt_x, pos_x, cnt_d_x;
  logic                        full;
  ioli_pkg::ctrl_t             ctrl;
  logic [CW-1:0]               at;
  ioli_pkg::status_e           res_status;

  logic [ioli_pkg::DATA_W-1:0] vals [CAPACITY];
  logic [ioli_pkg::DATA_W-1:0] vals_pad [NS];
  logic [NS-1:0]               flags_pad;
  ioli_pkg::scan_st_t          scan_st;
  logic [SW-1:0]               scan_idx;
  logic [ioli_pkg::DATA_W-1:0] scan_val;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ioli_pkg::FSM_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cnt_x = XW'(count_q);
  assign pos_x = XW'(position_i);
  assign full  = (cnt_x == XW'(CAPACITY));

  always_comb begin
    ctrl.cmd   = ioli_pkg::CMD_NOP;
    ctrl.key   = value_i;
    at         = count_q;
    count_d    = count_q;
    res_status = ioli_pkg::ST_OK;
    go_scan    = 1'b0;
    if (in_acc) begin
      case (ioli_pkg::opcode_e'(opcode_i))
        ioli_pkg::OP_INSERT_AT: begin
          if (full) begin
            res_status = ioli_pkg::ST_FULL;
          end else if (pos_x > cnt_x) begin
            res_status = ioli_pkg::ST_RANGE;
          end else begin
            ctrl.cmd = ioli_pkg::CMD_INS;
            at       = CW'(pos_x);
            count_d  = count_q + CW'(1);
          end
        end
        ioli_pkg::OP_APPEND: begin
          if (full) begin
            res_status = ioli_pkg::ST_FULL;
          end else begin
            ctrl.cmd = ioli_pkg::CMD_INS;
            count_d  = count_q + CW'(1);
          end
        end
        ioli_pkg::OP_REMOVE_AT: begin
          if (pos_x >= cnt_x) begin
            res_status = ioli_pkg::ST_RANGE;
          end else begin
            ctrl.cmd = ioli_pkg::CMD_REM;
            at       = CW'(pos_x);
            count_d  = count_q - CW'(1);
          end
        end
        ioli_pkg::OP_REMOVE_LAST: begin
          if (count_q == '0) begin
            res_status = ioli_pkg::ST_RANGE;
          end else begin
            ctrl.cmd = ioli_pkg::CMD_REM;
            at       = count_q - CW'(1);
            count_d  = count_q - CW'(1);
          end
        end
        ioli_pkg::OP_SEARCH: begin
          ctrl.cmd = ioli_pkg::CMD_MEQ;
          go_scan  = 1'b1;
        end
        ioli_pkg::OP_READ_AT: begin
          if (pos_x >= cnt_x) begin
            res_status = ioli_pkg::ST_RANGE;
          end else begin
            ctrl.cmd = ioli_pkg::CMD_MPOS;
            at       = CW'(pos_x);
            go_scan  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_d_x   = XW'(count_d);
  assign load_now  = in_acc && !go_scan;
  assign load_scan = (state_q == ioli_pkg::FSM_SCAN) && (scan_st.hit || scan_st.last) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ioli_pkg::FSM_IDLE: begin
        if (in_acc && go_scan) begin
          state_d = ioli_pkg::FSM_SCAN;
        end
      end
      ioli_pkg::FSM_SCAN: begin
        if (load_scan) begin
          state_d = ioli_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = ioli_pkg::FSM_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || load_now || load_scan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ioli_pkg::FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      search_q <= (ioli_pkg::opcode_e'(opcode_i) == ioli_pkg::OP_SEARCH);
    end
    if (load_now) begin
      status_q <= res_status;
      rd_q     <= '0;
      fidx_q   <= '0;
      ent_q    <= cnt_d_x[ioli_pkg::CNT_W-1:0];
    end else if (load_scan) begin
      ent_q <= cnt_x[ioli_pkg::CNT_W-1:0];
      if (search_q) begin
        status_q <= scan_st.hit ? ioli_pkg::ST_OK : ioli_pkg::ST_NOT_FOUND;
        rd_q     <= '0;
        fidx_q   <= scan_st.hit ? scan_idx[ioli_pkg::FIDX_W-1:0] : '0;
      end else begin
        status_q <= ioli_pkg::ST_OK;
        rd_q     <= scan_val;
        fidx_q   <= '0;
      end
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ioli_pkg::DATA_W-1:0] left, right;
    logic                        flag;
    if (k == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid_l
      assign left = vals[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = vals[k];
    end else begin : g_mid_r
      assign right = vals[k+1];
    end
    ioli_cell #(
      .CW (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .at_i    (at),
      .idx_i   (CW'(k)),
      .left_i  (left),
      .right_i (right),
      .value_o (vals[k]),
      .flag_o  (flag)
    );
    assign vals_pad[k]  = vals[k];
    assign flags_pad[k] = flag;
  end

  for (genvar k = CAPACITY; k < NS; k++) begin : g_pad
    assign vals_pad[k]  = '0;
    assign flags_pad[k] = 1'b0;
  end

  ioli_scan #(
    .NCH (NCH)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && go_scan),
    .step_i   ((state_q == ioli_pkg::FSM_SCAN) && !(scan_st.hit || scan_st.last)),
    .flags_i  (flags_pad),
    .values_i (vals_pad),
    .st_o     (scan_st),
    .idx_o    (scan_idx),
    .value_o  (scan_val)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rd_q;
  assign found_index_o = fidx_q;
  assign entry_count_o = ent_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= XW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
              count_q == $past(count_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full && (opcode_i == ioli_pkg::OP_INSERT_AT || opcode_i == ioli_pkg::OP_APPEND))
    |=> $stable(count_q))
    else $error("insert into full list changed the count");

  a_search_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == ioli_pkg::OP_SEARCH) |=> (state_q == ioli_pkg::FSM_SCAN))
    else $error("search transfer did not start a scan");

endmodule
